[hw/rtl/assert_macros.svh]
// assertion helper macros for the hash core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`endif

[hw/rtl/sha512_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha512_pkg: shared types and constants
// Initial hash values, round constants, queue entry type and engine states.
// ----------------------------------------------------------------------------
package sha512_pkg;

	localparam int WordW = 64;
	localparam int RoundTotal = 80;

	localparam logic [WordW-1:0] InitChain [8] = '{
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
		64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
		64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
	};

	localparam logic [WordW-1:0] RoundKey [RoundTotal] = '{
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
	};

	// classified word handed from front to back
	typedef struct packed {
		logic [WordW-1:0] word;   // masked and padded word
		logic [3:0]       cnt;    // valid bytes of a last word (0..8)
		logic             fin;    // last word of the message (length blocks follow)
		logic             extra;  // full last word: a separate 0x80 word must follow
	} entry_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_ROUND,
		ST_ADD,
		ST_PAD,
		ST_EMIT
	} eng_state_t;

	function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x, input int n);
		rotr = (x >> n) | (x << (WordW - n));
	endfunction

endpackage

[hw/rtl/sha512_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha512_front: word classifier
// Masks short last words, inserts the 0x80 marker and writes a small queue.
// ----------------------------------------------------------------------------
module sha512_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [63:0]                  in_word,
	input  logic [3:0]                   in_count,
	input  logic                         in_last,
	output logic                         q_valid,
	input  logic                         q_ready,
	output sha512_pkg::entry_t           q_data
);
	import sha512_pkg::*;

	entry_t      mem_q [2];
	logic        wp_q, rp_q;
	logic [1:0]  cnt_q;
	entry_t      ent;
	logic [3:0]  n;
	logic [63:0] mask, mark;

	// classify the incoming word
	always_comb begin
		n = in_last ? ((in_count > 4'd8) ? 4'd8 : in_count) : 4'd8;
		mask = (n == 4'd0) ? 64'd0 : ~(64'hffffffffffffffff >> {n[3:0], 3'b000});
		mark = (n == 4'd8) ? 64'd0 : (64'h8000000000000000 >> {n[2:0], 3'b000});
		ent.word = (in_word & mask) | (in_last ? mark : 64'd0);
		ent.cnt = n;
		ent.fin = in_last;
		ent.extra = in_last && (n == 4'd8);
	end

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_data = mem_q[rp_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) mem_q[wp_q] <= ent;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) wp_q <= ~wp_q;
			if (q_valid && q_ready) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
		end
	end
endmodule

[hw/rtl/sha512_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha512_back: compression engine
// Loads block words, runs 80 rounds one per cycle, pads and emits the digest.
// ----------------------------------------------------------------------------
module sha512_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	output logic                 q_ready,
	input  sha512_pkg::entry_t   q_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           out_index,
	output logic [63:0]          out_word,
	output logic                 out_last,
	output logic                 busy
);
	import sha512_pkg::*;

	eng_state_t  state_q, state_d;
	logic [63:0] h_q [8];
	logic [63:0] v_q [8];
	logic [63:0] w_q [16];
	logic [3:0]  fill_q;
	logic [6:0]  rnd_q;
	logic [63:0] bytes_q;
	logic        fin_q, extra_q;
	logic        len_done_q;
	logic        mark_hi_q;
	logic [2:0]  oidx_q;
	logic        load_en, pad_en;
	logic [63:0] ld_word, wt, w15, w2, t1, t2, s0, s1, ch, mj;

	// length-word selection while padding; a marker in the last two slots
	// pushes the length into one more block
	always_comb begin
		if (extra_q) ld_word = 64'h8000000000000000;
		else if (mark_hi_q) ld_word = 64'd0;
		else if (fill_q == 4'd14) ld_word = {61'd0, bytes_q[63:61]};
		else if (fill_q == 4'd15) ld_word = {bytes_q[60:0], 3'b000};
		else ld_word = 64'd0;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD:  if (q_valid && fill_q == 4'd15) state_d = ST_ROUND;
				else if (q_valid && q_data.fin) state_d = ST_PAD;
			ST_PAD:   if (fill_q == 4'd15) state_d = ST_ROUND;
			ST_ROUND: if (rnd_q == 7'(RoundTotal - 1)) state_d = ST_ADD;
			ST_ADD:   state_d = fin_q ? (len_done_q ? ST_EMIT : ST_PAD) : ST_LOAD;
			ST_EMIT:  if (out_ready && oidx_q == 3'd7) state_d = ST_LOAD;
			default:  state_d = ST_LOAD;
		endcase
	end

	// outputs
	always_comb begin
		q_ready = 1'b0;
		out_valid = 1'b0;
		load_en = 1'b0;
		pad_en = 1'b0;
		unique case (state_q)
			ST_LOAD: begin q_ready = 1'b1; load_en = q_valid; end
			ST_PAD:  pad_en = 1'b1;
			ST_EMIT: out_valid = 1'b1;
			default: ;
		endcase
	end

	assign out_index = oidx_q;
	assign out_word = h_q[oidx_q];
	assign out_last = (oidx_q == 3'd7);
	assign busy = (state_q != ST_LOAD);

	// round datapath
	always_comb begin
		w15 = w_q[4'(rnd_q - 7'd15)];
		w2 = w_q[4'(rnd_q - 7'd2)];
		if (rnd_q < 7'd16) wt = w_q[rnd_q[3:0]];
		else wt = w_q[rnd_q[3:0]] + (rotr(w15, 1) ^ rotr(w15, 8) ^ (w15 >> 7))
			+ w_q[4'(rnd_q - 7'd7)] + (rotr(w2, 19) ^ rotr(w2, 61) ^ (w2 >> 6));
		s1 = rotr(v_q[4], 14) ^ rotr(v_q[4], 18) ^ rotr(v_q[4], 41);
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1 = v_q[7] + s1 + ch + RoundKey[rnd_q] + wt;
		s0 = rotr(v_q[0], 28) ^ rotr(v_q[0], 34) ^ rotr(v_q[0], 39);
		mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2 = s0 + mj;
	end

	// schedule window
	always_ff @(posedge clk) begin
		if (load_en) w_q[fill_q] <= q_data.word;
		else if (pad_en) w_q[fill_q] <= ld_word;
		else if (state_q == ST_ROUND) w_q[rnd_q[3:0]] <= wt;
	end

	// control and chaining state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			fill_q <= 4'd0;
			rnd_q <= 7'd0;
			bytes_q <= 64'd0;
			fin_q <= 1'b0;
			extra_q <= 1'b0;
			len_done_q <= 1'b0;
			mark_hi_q <= 1'b0;
			oidx_q <= 3'd0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= InitChain[i];
				v_q[i] <= 64'd0;
			end
		end else begin
			state_q <= state_d;
			if (load_en) begin
				fill_q <= fill_q + 4'd1;
				bytes_q <= bytes_q + (q_data.fin ? {60'd0, q_data.cnt} : 64'd8);
				fin_q <= q_data.fin;
				extra_q <= q_data.extra;
				len_done_q <= 1'b0;
				mark_hi_q <= q_data.fin && !q_data.extra && (fill_q >= 4'd14);
			end
			if (pad_en) begin
				fill_q <= fill_q + 4'd1;
				extra_q <= 1'b0;
				if (extra_q) mark_hi_q <= (fill_q >= 4'd14);
				if (fill_q == 4'd15 && !extra_q && !mark_hi_q) len_done_q <= 1'b1;
			end
			if (state_d == ST_ROUND && state_q != ST_ROUND)
				for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
			if (state_q == ST_ROUND) begin
				rnd_q <= rnd_q + 7'd1;
				v_q[7] <= v_q[6];
				v_q[6] <= v_q[5];
				v_q[5] <= v_q[4];
				v_q[4] <= v_q[3] + t1;
				v_q[3] <= v_q[2];
				v_q[2] <= v_q[1];
				v_q[1] <= v_q[0];
				v_q[0] <= t1 + t2;
			end
			if (state_q == ST_ADD) begin
				rnd_q <= 7'd0;
				mark_hi_q <= 1'b0;
				for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
			end
			if (state_q == ST_EMIT && out_ready) begin
				oidx_q <= oidx_q + 3'd1;
				if (oidx_q == 3'd7) begin
					for (int i = 0; i < 8; i++) h_q[i] <= InitChain[i];
					bytes_q <= 64'd0;
					fin_q <= 1'b0;
					len_done_q <= 1'b0;
					fill_q <= 4'd0;
				end
			end
		end
	end
endmodule

[hw/rtl/sha512_hash_core_top.sv]
`timescale 1ns / 1ps
// SHA-512 hash core.
// s_axis carries message words: tdata is the 64-bit big-endian word, tuser the
// byte count (0..8, larger counts clamp to 8, read only on the last word), tlast marks the final word.
// m_axis returns the digest as eight transfers: tdata the digest word, tuser
// its index (0 most significant), tlast on the eighth.
// A front stage masks the last word and places the 0x80 marker, then writes a
// two-entry queue. The back engine takes one word a cycle into its 16-word
// window while it is loading, and takes none while a block runs its 80 rounds
// and the add into the hash state. After the last word one or two padding
// blocks run, each filled and then compressed, then the eight digest
// transfers follow. A stalled m_axis holds the digest; the queue then
// fills and s_axis tready drops. Reset loads the initial hash values and
// empties the queue.
// ----------------------------------------------------------------------------
// sha512_hash_core_top: stream wrapper
// Connects the front classifier, the queue and the compression engine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module sha512_hash_core_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // message_word
	input  logic [3:0]  s_axis_tuser,   // byte_count
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // digest_word
	output logic [2:0]  m_axis_tuser,   // digest_index
	output logic        m_axis_tlast
);
	import sha512_pkg::*;

	logic   q_valid, q_ready, busy;
	entry_t q_data;

	// word classifier and queue
	sha512_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_word(s_axis_tdata), .in_count(s_axis_tuser), .in_last(s_axis_tlast),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
	);

	// compression engine
	sha512_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_index(m_axis_tuser), .out_word(m_axis_tdata), .out_last(m_axis_tlast),
		.busy(busy)
	);

	// the engine never takes from the queue while it is busy
	`ASSERT_CLK(a_no_pop_busy, clk, arst_n, !(q_ready && busy), "queue popped while busy")
	// digest transfers only come from a busy engine
	`ASSERT_CLK(a_out_busy, clk, arst_n, !m_axis_tvalid || busy, "output without busy")
endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: SHA-512 hash core testbench
// Drives messages as word streams, hashes them in a local SHA-512 predictor
// and checks each digest transfer against the expected queue.
// ----------------------------------------------------------------------------
module tb_top;
	import sha512_pkg::*;

	typedef struct packed {
		logic [2:0]  idx;
		logic [63:0] word;
		logic        lst;
	} digest_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;
	logic [3:0]  s_axis_tuser;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [63:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tlast;

	// predictor state
	logic [63:0] hash_state [8];
	logic [63:0] block_buf [16];
	int unsigned block_fill;
	logic [63:0] msg_bytes;

	digest_t     digest_q [$];
	int unsigned error_count;
	longint      cycle_count;
	int          hold_cycles;
	bit          random_gaps;

	sha512_hash_core_top dut (.*);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 600000) begin
				$display("tb_top: done, errors");
				$finish;
			end
		end
	end

	function automatic logic [63:0] ror64(logic [63:0] x, int n);
		return (x >> n) | (x << (64 - n));
	endfunction

	// one 80-round compression of the held block
	function automatic void compress_held();
		logic [63:0] v [8];
		logic [63:0] w [16];
		logic [63:0] sch, t1, t2, w15, w2;
		for (int i = 0; i < 8; i++) v[i] = hash_state[i];
		for (int i = 0; i < 16; i++) w[i] = block_buf[i];
		for (int t = 0; t < RoundTotal; t++) begin
			if (t < 16) sch = w[t];
			else begin
				w15 = w[(t - 15) & 15];
				w2 = w[(t - 2) & 15];
				sch = w[t & 15] + (ror64(w15, 1) ^ ror64(w15, 8) ^ (w15 >> 7))
					+ w[(t - 7) & 15] + (ror64(w2, 19) ^ ror64(w2, 61) ^ (w2 >> 6));
				w[t & 15] = sch;
			end
			t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundKey[t] + sch;
			t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			for (int i = 7; i > 0; i--) v[i] = v[i - 1];
			v[4] = v[4] + t1;
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) hash_state[i] += v[i];
	endfunction

	function automatic void load_word(logic [63:0] w);
		block_buf[block_fill] = w;
		block_fill++;
		if (block_fill == 16) begin
			block_fill = 0;
			compress_held();
		end
	endfunction

	function automatic void hash_reset();
		for (int i = 0; i < 8; i++) hash_state[i] = InitChain[i];
		block_fill = 0;
		msg_bytes = 0;
	endfunction

	// fold one accepted word into the hash, queue the digest on the last word
	function automatic void hash_word(logic [63:0] word, logic [3:0] cnt, logic fin);
		int unsigned n;
		digest_t d;
		if (!fin) begin
			msg_bytes += 8;
			load_word(word);
			return;
		end
		n = (cnt > 8) ? 8 : cnt;
		msg_bytes += n;
		if (n == 0) word = '0;
		else word &= ~64'd0 << (64 - 8 * n);
		if (n < 8) load_word(word | (64'h80 << (56 - 8 * n)));
		else begin
			load_word(word);
			load_word(64'h8000000000000000);
		end
		while (block_fill != 14) load_word('0);
		load_word(msg_bytes >> 61);
		load_word(msg_bytes << 3);
		for (int i = 0; i < 8; i++) begin
			d.idx = i[2:0];
			d.word = hash_state[i];
			d.lst = (i == 7);
			digest_q.push_back(d);
		end
		for (int i = 0; i < 8; i++) hash_state[i] = InitChain[i];
		block_fill = 0;
		msg_bytes = 0;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		error_count++;
	endtask

	// send one word, waiting for the transfer; tready is sampled mid-cycle
	task automatic send_word(logic [63:0] word, logic [3:0] cnt, logic fin);
		int gap;
		logic rdy;
		gap = random_gaps ? $urandom_range(0, 16) : 0;
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= word;
		s_axis_tuser <= cnt;
		s_axis_tlast <= fin;
		do begin
			@(negedge clk);
			rdy = s_axis_tready;
			@(posedge clk);
		end while (!rdy);
		hash_word(word, cnt, fin);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// message of full words then a last word with the given count
	task automatic send_message(int words, logic [3:0] last_cnt);
		for (int i = 0; i < words; i++) send_word(rand64(), 4'($urandom), 1'b0);
		send_word(rand64(), last_cnt, 1'b1);
	endtask

	// stop offering and wait for every expected digest
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (digest_q.size() != 0) @(posedge clk);
	endtask

	// digest checker with receiver stalls; outputs sampled mid-cycle
	initial begin
		digest_t d;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_cycles > 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end else if (random_gaps && $urandom_range(0, 2) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(negedge clk);
			if (m_axis_tvalid) begin
				if (digest_q.size() == 0) begin
					report_mismatch("unexpected digest", m_axis_tdata, '0);
				end else begin
					d = digest_q.pop_front();
					if (m_axis_tuser !== d.idx) report_mismatch("index", m_axis_tuser, d.idx);
					if (m_axis_tdata !== d.word) report_mismatch("word", m_axis_tdata, d.word);
					if (m_axis_tlast !== d.lst) report_mismatch("tlast", m_axis_tlast, d.lst);
				end
			end
			@(posedge clk);
		end
	end

	// known vectors: empty, last-word byte counts 0, 1, 3, 7, 8, 9 and 15, a length near a block boundary
	task automatic test_directed();
		send_word('0, 4'd0, 1'b1);
		send_word(64'h6162630000000000, 4'd3, 1'b1);
		send_word(~64'd0, 4'd15, 1'b1);
		send_word(~64'd0, 4'd8, 1'b1);
		send_word(~64'd0, 4'd1, 1'b1);
		send_word(64'h0123456789abcdef, 4'd7, 1'b1);
		send_word(~64'd0, 4'd3, 1'b0);
		send_word('0, 4'd0, 1'b0);
		send_word(~64'd0, 4'd9, 1'b1);
		send_message(13, 4'd8);
		drain();
	endtask

	task automatic test_random();
		random_gaps = 1'b1;
		for (int m = 0; m < 25; m++)
			send_message($urandom_range(0, 15) + ($urandom_range(0, 4) == 0 ? 16 : 0),
				4'($urandom));
		drain();
	endtask

	// long receiver stall while words keep coming
	task automatic test_backpressure();
		hold_cycles = 1500;
		for (int m = 0; m < 4; m++) send_message($urandom_range(0, 3), 4'($urandom_range(1, 8)));
		drain();
		send_message(14, 4'd8);
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		s_axis_tlast = 1'b0;
		error_count = 0;
		hold_cycles = 0;
		random_gaps = 1'b0;
		hash_reset();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		test_backpressure();
		repeat (300) @(posedge clk);
		if (error_count == 0 && digest_q.size() == 0) $display("tb_top: done, clean");
		else $display("tb_top: done, errors");
		$finish;
	end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/sha512_pkg.sv
hw/rtl/sha512_front.sv
hw/rtl/sha512_back.sv
hw/rtl/sha512_hash_core_top.sv
tb/sv/tb_top.sv
